// ===== sv/utf8l1_pkg.sv =====
// Shared types and constants for the UTF-8 to Latin-1 transcoder.
`timescale 1ns / 1ps

package utf8l1_pkg;

   localparam logic [2:0] ST_ACCEPT   = 3'd0;
   localparam logic [2:0] ST_ONE_LEFT = 3'd1;
   localparam logic [2:0] ST_TWO_LEFT = 3'd2;
   localparam logic [2:0] ST_AFTER_E0 = 3'd3;
   localparam logic [2:0] ST_AFTER_ED = 3'd4;
   localparam logic [2:0] ST_AFTER_F0 = 3'd5;
   localparam logic [2:0] ST_AFTER_F1 = 3'd6;
   localparam logic [2:0] ST_AFTER_F4 = 3'd7;

   localparam logic [7:0] SUBST_CHAR   = 8'h3F;
   localparam logic [7:0] CUTOFF_RESET = 8'hFF;
   localparam logic [7:0] CONT_MASK    = 8'h3F;
   localparam logic [7:0] ASCII_LIMIT  = 8'h80;

   localparam logic [0:0] REG_CUTOFF = 1'b0;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_of_string;
   } result_type;

   typedef struct packed {
      logic [1:0]            count;
      result_type [1:0]      item;
   } push_type;

endpackage

// ===== sv/utf8l1_csr.sv =====
// Configuration register file: cutoff code point behind an APB-style port.
`timescale 1ns / 1ps

module utf8l1_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [7:0]  cutoff
);

   logic [7:0] cutoff_ff;
   logic [7:0] cutoff_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_comb begin
      cutoff_in = cutoff_ff;
      if (wr_en && (paddr[2:2] == utf8l1_pkg::REG_CUTOFF)) begin
         cutoff_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= utf8l1_pkg::CUTOFF_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr[2:2] == utf8l1_pkg::REG_CUTOFF) begin
         prdata = {24'd0, cutoff_ff};
      end
   end

   assign cutoff = cutoff_ff;

endmodule

// ===== sv/utf8l1_decode.sv =====
// Strict UTF-8 decode step: one byte in, up to two output bytes and next state out.
`timescale 1ns / 1ps

module utf8l1_decode (
   input  logic [2:0]           state,
   input  logic [20:0]          partial,
   input  logic [7:0]           in_byte,
   input  logic                 end_of_string,
   input  logic [7:0]           cutoff,
   output utf8l1_pkg::push_type push,
   output logic [2:0]           state_next,
   output logic [20:0]          partial_next
);

   localparam logic [1:0] FEED_DONE = 2'd0;
   localparam logic [1:0] FEED_MORE = 2'd1;
   localparam logic [1:0] FEED_BAD  = 2'd2;

   typedef struct packed {
      logic [1:0]  code;
      logic [2:0]  state;
      logic [20:0] value;
   } feed_type;

   function automatic feed_type feed_lead(input logic [7:0] b);
      feed_type f;
      f.code  = FEED_BAD;
      f.state = utf8l1_pkg::ST_ACCEPT;
      f.value = 21'd0;
      if (b < utf8l1_pkg::ASCII_LIMIT) begin
         f.code  = FEED_DONE;
         f.value = {13'd0, b};
      end else if (b < 8'hC2) begin
         f.code = FEED_BAD;
      end else if (b < 8'hE0) begin
         f.code  = FEED_MORE;
         f.state = utf8l1_pkg::ST_ONE_LEFT;
         f.value = {16'd0, b[4:0]};
      end else if (b < 8'hF0) begin
         f.code  = FEED_MORE;
         f.state = (b == 8'hE0) ? utf8l1_pkg::ST_AFTER_E0 :
                   (b == 8'hED) ? utf8l1_pkg::ST_AFTER_ED : utf8l1_pkg::ST_TWO_LEFT;
         f.value = {17'd0, b[3:0]};
      end else if (b < 8'hF5) begin
         f.code  = FEED_MORE;
         f.state = (b == 8'hF0) ? utf8l1_pkg::ST_AFTER_F0 :
                   (b == 8'hF4) ? utf8l1_pkg::ST_AFTER_F4 : utf8l1_pkg::ST_AFTER_F1;
         f.value = {18'd0, b[2:0]};
      end
      return f;
   endfunction

   function automatic feed_type feed_cont(input logic [2:0] st, input logic [20:0] pt,
                                          input logic [7:0] b);
      feed_type   f;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [2:0] nxt;
      lo  = 8'h80;
      hi  = 8'hBF;
      nxt = utf8l1_pkg::ST_ACCEPT;
      unique case (st)
         utf8l1_pkg::ST_ONE_LEFT: nxt = utf8l1_pkg::ST_ACCEPT;
         utf8l1_pkg::ST_TWO_LEFT: nxt = utf8l1_pkg::ST_ONE_LEFT;
         utf8l1_pkg::ST_AFTER_E0: begin
            lo  = 8'hA0;
            nxt = utf8l1_pkg::ST_ONE_LEFT;
         end
         utf8l1_pkg::ST_AFTER_ED: begin
            hi  = 8'h9F;
            nxt = utf8l1_pkg::ST_ONE_LEFT;
         end
         utf8l1_pkg::ST_AFTER_F0: begin
            lo  = 8'h90;
            nxt = utf8l1_pkg::ST_TWO_LEFT;
         end
         utf8l1_pkg::ST_AFTER_F1: nxt = utf8l1_pkg::ST_TWO_LEFT;
         utf8l1_pkg::ST_AFTER_F4: begin
            hi  = 8'h8F;
            nxt = utf8l1_pkg::ST_TWO_LEFT;
         end
         default: begin
            lo  = 8'hFF;
            hi  = 8'h00;
            nxt = utf8l1_pkg::ST_ACCEPT;
         end
      endcase
      f.state = nxt;
      f.value = {pt[14:0], b[5:0] & utf8l1_pkg::CONT_MASK[5:0]};
      if ((b < lo) || (b > hi)) begin
         f.code = FEED_BAD;
      end else if (nxt == utf8l1_pkg::ST_ACCEPT) begin
         f.code = FEED_DONE;
      end else begin
         f.code = FEED_MORE;
      end
      return f;
   endfunction

   function automatic logic [7:0] to_char(input logic [20:0] cp, input logic [7:0] lim);
      return (cp <= {13'd0, lim}) ? cp[7:0] : utf8l1_pkg::SUBST_CHAR;
   endfunction

   feed_type fa;
   feed_type f1;

   assign fa = feed_lead(in_byte);
   assign f1 = (state == utf8l1_pkg::ST_ACCEPT) ? fa : feed_cont(state, partial, in_byte);

   always_comb begin
      push         = '0;
      state_next   = utf8l1_pkg::ST_ACCEPT;
      partial_next = 21'd0;
      case (f1.code)
         FEED_DONE: begin
            push.item[0].out_char = to_char(f1.value, cutoff);
            push.count            = 2'd1;
         end
         FEED_MORE: begin
            state_next   = f1.state;
            partial_next = f1.value;
         end
         default: begin
            push.item[0].out_char = utf8l1_pkg::SUBST_CHAR;
            push.count            = 2'd1;
            if (state != utf8l1_pkg::ST_ACCEPT) begin
               case (fa.code)
                  FEED_DONE: begin
                     push.item[1].out_char = to_char(fa.value, cutoff);
                     push.count            = 2'd2;
                  end
                  FEED_MORE: begin
                     state_next   = fa.state;
                     partial_next = fa.value;
                  end
                  default: begin
                     push.item[1].out_char = utf8l1_pkg::SUBST_CHAR;
                     push.count            = 2'd2;
                  end
               endcase
            end
         end
      endcase
      if (end_of_string) begin
         if (state_next != utf8l1_pkg::ST_ACCEPT) begin
            if (push.count == 2'd0) begin
               push.item[0].out_char = utf8l1_pkg::SUBST_CHAR;
               push.count            = 2'd1;
            end else begin
               push.item[1].out_char = utf8l1_pkg::SUBST_CHAR;
               push.count            = 2'd2;
            end
         end
         state_next   = utf8l1_pkg::ST_ACCEPT;
         partial_next = 21'd0;
         case (push.count)
            2'd1:    push.item[0].last_of_string = 1'b1;
            2'd2:    push.item[1].last_of_string = 1'b1;
            default: ;
         endcase
      end
   end

endmodule

// ===== sv/utf8l1_outbuf.sv =====
// Two-entry response queue: up to two bytes in per cycle, one out unless rd_stall.
`timescale 1ns / 1ps

module utf8l1_outbuf (
   input  logic                   clock,
   input  logic                   reset,
   input  utf8l1_pkg::push_type   push,
   input  logic                   rd_stall,
   output logic                   rd_valid,
   output utf8l1_pkg::result_type rd_data,
   output logic [1:0]             space
);

   utf8l1_pkg::result_type q_ff [2];
   utf8l1_pkg::result_type q_in [2];
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic [1:0]             count_pop;
   logic                   pop;

   assign rd_valid  = (count_ff != 2'd0);
   assign rd_data   = q_ff[0];
   assign pop       = rd_valid && !rd_stall;
   assign count_pop = count_ff - {1'b0, pop};
   assign space     = 2'd2 - count_pop;

   always_comb begin
      q_in[0] = pop ? q_ff[1] : q_ff[0];
      q_in[1] = q_ff[1];
      case (count_pop)
         2'd0: begin
            if (push.count != 2'd0) begin
               q_in[0] = push.item[0];
            end
            if (push.count == 2'd2) begin
               q_in[1] = push.item[1];
            end
         end
         2'd1: begin
            if (push.count != 2'd0) begin
               q_in[1] = push.item[0];
            end
         end
         default: ;
      endcase
      count_in = count_pop + push.count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

endmodule

// ===== sv/utf8_to_latin1_transcoder_core.sv =====
// Top level of the strict UTF-8 to Latin-1 transcoder.
//
// Request channel: one UTF-8 byte per request (req_in_byte) with
// req_end_of_string set on the last byte of a string. Response channel: one
// Latin-1 byte per response (rsp_out_char), 0x3F for anything rejected or
// above the cutoff, with rsp_last_of_string on the last byte of a string.
// A request yields zero, one or two responses.
// A taken request is held in the request register and decoded into the
// response queue. Throughput: one request per cycle while rsp_stall is low and
// each yields at most one response; a request that yields two holds the
// request register until the queue has room for both. The two-entry response
// queue and the request register set this rate. The cutoff register (address
// 0) is written over the APB-style port; the user must write it only while the
// block is idle, which the block itself does not enforce. Reset (synchronous)
// sets it to 0xFF, empties the request register and response queue and returns
// the decoder to its accept state. While rsp_stall is high the queue holds its
// head; once it lacks room for the held request's responses, req_stall rises
// and the request register holds its byte.
`timescale 1ns / 1ps

module utf8_to_latin1_transcoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_of_string,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [7:0]             in_byte_ff;
   logic [7:0]             in_byte_in;
   logic                   in_eos_ff;
   logic                   in_eos_in;
   logic [2:0]             state_ff;
   logic [2:0]             state_in;
   logic [20:0]            partial_ff;
   logic [20:0]            partial_in;
   logic [2:0]             dec_state;
   logic [20:0]            dec_partial;
   logic [7:0]             cutoff;
   logic [1:0]             space;
   logic                   process;
   logic                   take;
   utf8l1_pkg::push_type   dec_push;
   utf8l1_pkg::push_type   buf_push;
   utf8l1_pkg::result_type head;

   utf8l1_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cutoff  (cutoff)
   );

   utf8l1_decode u_decode (
      .state         (state_ff),
      .partial       (partial_ff),
      .in_byte       (in_byte_ff),
      .end_of_string (in_eos_ff),
      .cutoff        (cutoff),
      .push          (dec_push),
      .state_next    (dec_state),
      .partial_next  (dec_partial)
   );

   assign process   = in_valid_ff && (dec_push.count <= space);
   assign req_stall = in_valid_ff && !process;
   assign take      = req_valid && !req_stall;

   always_comb begin
      buf_push = dec_push;
      if (!process) begin
         buf_push.count = 2'd0;
      end
   end

   utf8l1_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .push     (buf_push),
      .rd_stall (rsp_stall),
      .rd_valid (rsp_valid),
      .rd_data  (head),
      .space    (space)
   );

   assign rsp_out_char       = head.out_char;
   assign rsp_last_of_string = head.last_of_string;

   always_comb begin
      in_valid_in = take ? 1'b1 : (in_valid_ff && !process);
      in_byte_in  = take ? req_in_byte : in_byte_ff;
      in_eos_in   = take ? req_end_of_string : in_eos_ff;
      state_in    = process ? dec_state : state_ff;
      partial_in  = process ? dec_partial : partial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= utf8l1_pkg::ST_ACCEPT;
         partial_ff  <= 21'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         partial_ff  <= partial_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_eos_ff  <= in_eos_in;
   end

endmodule
